@@ hdl/lmc_pkg.sv @@
`default_nettype none
package lmc_pkg;

  localparam int IDX_W                  = 10;
  localparam int IDX_LIMIT              = 1023;
  localparam int DEFAULT_MAX_LINE_ITEMS = 1024;

  typedef enum logic [1:0] {
    PH_LEAD  = 2'd0,
    PH_TOKEN = 2'd1,
    PH_GAP   = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  localparam logic [1:0] KIND_NONE     = 2'd0;
  localparam logic [1:0] KIND_BULLET   = 2'd1;
  localparam logic [1:0] KIND_NUMBERED = 2'd2;

  localparam logic [1:0] STYLE_NONE    = 2'd0;
  localparam logic [1:0] STYLE_DECIMAL = 2'd1;
  localparam logic [1:0] STYLE_ROMAN   = 2'd2;
  localparam logic [1:0] STYLE_BRACKET = 2'd3;

  localparam logic [15:0] CH_UPPER_I = 16'h0049;
  localparam logic [15:0] CH_UPPER_V = 16'h0056;
  localparam logic [15:0] CH_UPPER_X = 16'h0058;
  localparam logic [15:0] CH_LOWER_I = 16'h0069;
  localparam logic [15:0] CH_LOWER_V = 16'h0076;
  localparam logic [15:0] CH_LOWER_X = 16'h0078;
  localparam logic [15:0] CH_COLON   = 16'h003A;
  localparam logic [15:0] CH_OPEN_BR = 16'h005B;
  localparam logic [15:0] CH_CLOSE_BR = 16'h005D;

endpackage
`default_nettype wire

@@ hdl/list_marker_classifier.sv @@
// List marker classifier.
// Input channel: one beat per page item of a text line (in_valid/in_ready), carrying
// the character flags, the code unit, the left coordinate and line_end on the last
// item of the line. Output channel: one beat per line (out_valid/out_ready), sent for
// the item that carries line_end, giving list kind, number style, text left edge and
// the marker's first and following item indices; a line that is no list gives zeros.
// A beat is taken into an input register, and the scan state and classification are
// updated from that register in one pass, so the block takes one item every cycle while no line_end item waits.
// A line's result is loaded into the output register as its line_end item leaves the
// input register. Items without line_end never wait on the output side;
// a line_end item waits in the input register only while an earlier result is still
// held, and then in_ready drops.
// Reset (synchronous, rst high) empties both registers and returns the scan to the
// leading-space phase with index zero; the same line state is restored after every
// line_end item. Item indices saturate at the smaller of MAX_LINE_ITEMS-1 and 1023.
`default_nettype none
module list_marker_classifier
  import lmc_pkg::*;
#(
  parameter int MAX_LINE_ITEMS = DEFAULT_MAX_LINE_ITEMS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               is_character,
  input  wire logic [15:0]        char_code,
  input  wire logic               space_flag,
  input  wire logic               digit_flag,
  input  wire logic               dot_flag,
  input  wire logic               alnum_flag,
  input  wire logic signed [31:0] left_coord,
  input  wire logic               line_end,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              list_kind,
  output logic [1:0]              number_style,
  output logic signed [31:0]      text_left,
  output logic [IDX_W-1:0]        marker_first,
  output logic [IDX_W-1:0]        marker_after
);

  localparam int IDX_CAP = (MAX_LINE_ITEMS - 1 < IDX_LIMIT) ? (MAX_LINE_ITEMS - 1) : IDX_LIMIT;

  // Input register.
  logic               s1_valid;
  logic               s1_chr;
  logic [15:0]        s1_code;
  logic               s1_space;
  logic               s1_digit;
  logic               s1_dot;
  logic               s1_alnum;
  logic signed [31:0] s1_left;
  logic               s1_line_end;
  logic               s1_adv;

  // Scan state.
  phase_t             phase, phase_next;
  logic [IDX_W-1:0]   item_index, item_index_next;
  logic [IDX_W-1:0]   token_start, token_start_next;
  logic [IDX_W-1:0]   token_end, token_end_next;
  logic               first_nonalnum, first_nonalnum_next;
  logic               first_open_br, first_open_br_next;
  logic               prev_chr, prev_chr_next;
  logic               prev_dec, prev_dec_next;
  logic               prev_dot, prev_dot_next;
  logic [15:0]        prev_code, prev_code_next;
  logic               dec_prefix_ok, dec_prefix_ok_next;
  logic               dec_inner_ok, dec_inner_ok_next;
  logic               roman_ok, roman_ok_next;
  logic               roman_fresh, roman_fresh_next;
  logic               roman_upper, roman_upper_next;
  logic               token_multi, token_multi_next;
  logic [1:0]         dec_kind, dec_kind_next;
  logic [1:0]         dec_style, dec_style_next;
  logic signed [31:0] dec_left, dec_left_next;

  // Masked flags of the registered item.
  logic        chr, is_space, is_digit, is_dot, is_alnum;
  logic [15:0] code;
  logic        prev_upper, prev_lower, prev_ends;
  logic [1:0]  cls_kind, cls_style;

  assign chr      = s1_chr;
  assign is_space = s1_chr & s1_space;
  assign is_digit = s1_chr & s1_digit;
  assign is_dot   = s1_chr & s1_dot;
  assign is_alnum = s1_chr & s1_alnum;
  assign code     = s1_chr ? s1_code : 16'd0;

  assign s1_adv   = s1_valid && (!s1_line_end || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  assign prev_upper = (prev_code == CH_UPPER_I) || (prev_code == CH_UPPER_V) ||
                      (prev_code == CH_UPPER_X);
  assign prev_lower = (prev_code == CH_LOWER_I) || (prev_code == CH_LOWER_V) ||
                      (prev_code == CH_LOWER_X);
  assign prev_ends  = prev_chr && (prev_dot || prev_code == CH_COLON);

  // Decision on the held token, made when the text item arrives.
  always_comb begin
    cls_kind  = KIND_NONE;
    cls_style = STYLE_NONE;
    priority if (!token_multi && first_nonalnum) begin
      cls_kind = KIND_BULLET;
    end else if (prev_ends && dec_prefix_ok) begin
      cls_kind  = KIND_NUMBERED;
      cls_style = STYLE_DECIMAL;
    end else if (prev_ends && roman_ok) begin
      cls_kind  = KIND_NUMBERED;
      cls_style = STYLE_ROMAN;
    end else if (token_multi && first_open_br && prev_chr && prev_code == CH_CLOSE_BR &&
                 dec_inner_ok) begin
      cls_kind  = KIND_NUMBERED;
      cls_style = STYLE_BRACKET;
    end else begin
      cls_kind = KIND_NONE;
    end
  end

  always_comb begin
    phase_next          = phase;
    token_start_next    = token_start;
    token_end_next      = token_end;
    first_nonalnum_next = first_nonalnum;
    first_open_br_next  = first_open_br;
    prev_chr_next       = prev_chr;
    prev_dec_next       = prev_dec;
    prev_dot_next       = prev_dot;
    prev_code_next      = prev_code;
    dec_prefix_ok_next  = dec_prefix_ok;
    dec_inner_ok_next   = dec_inner_ok;
    roman_ok_next       = roman_ok;
    roman_fresh_next    = roman_fresh;
    roman_upper_next    = roman_upper;
    token_multi_next    = token_multi;
    dec_kind_next       = dec_kind;
    dec_style_next      = dec_style;
    dec_left_next       = dec_left;
    item_index_next     = (item_index < IDX_W'(IDX_CAP)) ? item_index + 1'b1 : item_index;

    unique case (phase)
      PH_LEAD: begin
        if (!is_space) begin
          token_start_next    = item_index;
          first_nonalnum_next = !is_alnum;
          first_open_br_next  = chr && (code == CH_OPEN_BR);
          prev_chr_next       = chr;
          prev_dec_next       = is_digit || is_dot;
          prev_dot_next       = is_dot;
          prev_code_next      = code;
          token_multi_next    = 1'b0;
          phase_next          = PH_TOKEN;
        end
      end
      PH_TOKEN: begin
        if (is_space) begin
          token_end_next = item_index;
          phase_next     = PH_GAP;
        end else begin
          // The held item is now known not to be the token's last one.
          if (!prev_dec) begin
            dec_prefix_ok_next = 1'b0;
          end
          if (token_multi && !prev_dec) begin
            dec_inner_ok_next = 1'b0;
          end
          if (roman_ok) begin
            priority if (!prev_chr) begin
              roman_ok_next = 1'b0;
            end else if (prev_dot) begin
              roman_ok_next = 1'b1;
            end else if (prev_upper && (roman_fresh || roman_upper)) begin
              roman_upper_next = 1'b1;
              roman_fresh_next = 1'b0;
            end else if (prev_lower && (roman_fresh || !roman_upper)) begin
              roman_upper_next = 1'b0;
              roman_fresh_next = 1'b0;
            end else begin
              roman_ok_next = 1'b0;
            end
          end
          token_multi_next = 1'b1;
          prev_chr_next    = chr;
          prev_dec_next    = is_digit || is_dot;
          prev_dot_next    = is_dot;
          prev_code_next   = code;
        end
      end
      PH_GAP: begin
        if (!is_space) begin
          dec_kind_next  = cls_kind;
          dec_style_next = cls_style;
          dec_left_next  = s1_left;
          phase_next     = PH_DONE;
        end
      end
      PH_DONE: begin
        phase_next = PH_DONE;
      end
      default: begin
        phase_next = PH_LEAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
    if (in_valid && in_ready) begin
      s1_chr      <= is_character;
      s1_code     <= char_code;
      s1_space    <= space_flag;
      s1_digit    <= digit_flag;
      s1_dot      <= dot_flag;
      s1_alnum    <= alnum_flag;
      s1_left     <= left_coord;
      s1_line_end <= line_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (s1_adv && s1_line_end)) begin
      phase          <= PH_LEAD;
      item_index     <= '0;
      token_start    <= '0;
      token_end      <= '0;
      first_nonalnum <= 1'b0;
      first_open_br  <= 1'b0;
      prev_chr       <= 1'b0;
      prev_dec       <= 1'b0;
      prev_dot       <= 1'b0;
      prev_code      <= '0;
      dec_prefix_ok  <= 1'b1;
      dec_inner_ok   <= 1'b1;
      roman_ok       <= 1'b1;
      roman_fresh    <= 1'b1;
      roman_upper    <= 1'b0;
      token_multi    <= 1'b0;
      dec_kind       <= KIND_NONE;
      dec_style      <= STYLE_NONE;
      dec_left       <= '0;
    end else if (s1_adv) begin
      phase          <= phase_next;
      item_index     <= item_index_next;
      token_start    <= token_start_next;
      token_end      <= token_end_next;
      first_nonalnum <= first_nonalnum_next;
      first_open_br  <= first_open_br_next;
      prev_chr       <= prev_chr_next;
      prev_dec       <= prev_dec_next;
      prev_dot       <= prev_dot_next;
      prev_code      <= prev_code_next;
      dec_prefix_ok  <= dec_prefix_ok_next;
      dec_inner_ok   <= dec_inner_ok_next;
      roman_ok       <= roman_ok_next;
      roman_fresh    <= roman_fresh_next;
      roman_upper    <= roman_upper_next;
      token_multi    <= token_multi_next;
      dec_kind       <= dec_kind_next;
      dec_style      <= dec_style_next;
      dec_left       <= dec_left_next;
    end
  end

  // Result register, loaded by the line_end item from the updated line state.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_line_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_adv && s1_line_end) begin
      if (phase_next == PH_DONE && dec_kind_next != KIND_NONE) begin
        list_kind    <= dec_kind_next;
        number_style <= dec_style_next;
        text_left    <= dec_left_next;
        marker_first <= token_start_next;
        marker_after <= token_end_next;
      end else begin
        list_kind    <= KIND_NONE;
        number_style <= STYLE_NONE;
        text_left    <= '0;
        marker_first <= '0;
        marker_after <= '0;
      end
    end
  end

  a_none_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && list_kind == KIND_NONE) |->
      (number_style == STYLE_NONE && text_left == 0 && marker_first == 0 &&
       marker_after == 0))
    else $error("non-list result carries nonzero fields");

  a_style_matches_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((list_kind == KIND_NONE || list_kind == KIND_BULLET ||
                    list_kind == KIND_NUMBERED) &&
                   ((list_kind == KIND_NUMBERED) == (number_style != STYLE_NONE))))
    else $error("list kind and number style disagree");

  a_index_capped: assert property (@(posedge clk) disable iff (rst)
    item_index <= IDX_W'(IDX_CAP))
    else $error("item index passed its cap");

  a_marker_order: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_GAP || phase == PH_DONE) |-> token_end >= token_start)
    else $error("marker ends before it starts");

  a_line_restart: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_line_end) |=> (phase == PH_LEAD && item_index == 0 && out_valid))
    else $error("line state not restored after line end");

endmodule
`default_nettype wire

@@ test/list_marker_classifier_checker.sv @@
`timescale 1ns / 100ps
module list_marker_classifier_checker
  import lmc_pkg::*;
#(
  parameter int MAX_LINE_ITEMS = DEFAULT_MAX_LINE_ITEMS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               is_character,
  input  logic [15:0]        char_code,
  input  logic               space_flag,
  input  logic               digit_flag,
  input  logic               dot_flag,
  input  logic               alnum_flag,
  input  logic signed [31:0] left_coord,
  input  logic               line_end,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         list_kind,
  input  logic [1:0]         number_style,
  input  logic signed [31:0] text_left,
  input  logic [IDX_W-1:0]   marker_first,
  input  logic [IDX_W-1:0]   marker_after,
  output int                 mismatch_count,
  output int                 lines_pending
);

  localparam int INDEX_CAP = (MAX_LINE_ITEMS - 1 < IDX_LIMIT) ? MAX_LINE_ITEMS - 1 : IDX_LIMIT;

  typedef struct packed {
    logic chr;
    logic sp;
    logic dg;
    logic dt;
    logic an;
  } glyph_flags_t;

  typedef struct {
    logic [1:0]         kind;
    logic [1:0]         style;
    logic signed [31:0] left;
    logic [IDX_W-1:0]   first;
    logic [IDX_W-1:0]   after;
  } line_verdict_t;

  line_verdict_t verdicts_due[$];

  phase_t             scan_phase;
  logic [IDX_W-1:0]   pos;
  logic [IDX_W-1:0]   tok_start;
  logic [IDX_W-1:0]   tok_end;
  logic               lone_symbol;
  logic               opens_bracket;
  logic               multi_item;
  glyph_flags_t       held_flags;
  logic [15:0]        held_code;
  logic               decimal_ok;
  logic               bracket_inner_ok;
  logic               roman_ok;
  logic               roman_unset;
  logic               roman_caps;
  logic [1:0]         found_kind;
  logic [1:0]         found_style;
  logic signed [31:0] found_left;

  task automatic restart_line();
    scan_phase       = PH_LEAD;
    pos              = '0;
    tok_start        = '0;
    tok_end          = '0;
    lone_symbol      = 1'b0;
    opens_bracket    = 1'b0;
    multi_item       = 1'b0;
    held_flags       = '0;
    held_code        = '0;
    decimal_ok       = 1'b1;
    bracket_inner_ok = 1'b1;
    roman_ok         = 1'b1;
    roman_unset      = 1'b1;
    roman_caps       = 1'b0;
    found_kind       = KIND_NONE;
    found_style      = STYLE_NONE;
    found_left       = '0;
  endtask

  // The held item is now known not to be the last of the token, so it joins the prefix.
  task automatic absorb_held();
    logic numeric;
    logic upper_letter;
    logic lower_letter;
    numeric      = held_flags.chr && (held_flags.dg || held_flags.dt);
    upper_letter = held_code == CH_UPPER_I || held_code == CH_UPPER_V || held_code == CH_UPPER_X;
    lower_letter = held_code == CH_LOWER_I || held_code == CH_LOWER_V || held_code == CH_LOWER_X;
    if (!numeric) decimal_ok = 1'b0;
    if (multi_item && !numeric) bracket_inner_ok = 1'b0;
    if (roman_ok) begin
      if (!held_flags.chr) begin
        roman_ok = 1'b0;
      end else if (held_flags.dt) begin
      end else if (upper_letter && (roman_unset || roman_caps)) begin
        roman_caps  = 1'b1;
        roman_unset = 1'b0;
      end else if (lower_letter && (roman_unset || !roman_caps)) begin
        roman_caps  = 1'b0;
        roman_unset = 1'b0;
      end else begin
        roman_ok = 1'b0;
      end
    end
  endtask

  task automatic judge_marker();
    found_kind  = KIND_NONE;
    found_style = STYLE_NONE;
    if (!multi_item && lone_symbol) begin
      found_kind = KIND_BULLET;
    end else if (held_flags.chr && (held_flags.dt || held_code == CH_COLON) &&
                 (decimal_ok || roman_ok)) begin
      found_kind  = KIND_NUMBERED;
      found_style = decimal_ok ? STYLE_DECIMAL : STYLE_ROMAN;
    end else if (multi_item && opens_bracket && held_flags.chr &&
                 held_code == CH_CLOSE_BR && bracket_inner_ok) begin
      found_kind  = KIND_NUMBERED;
      found_style = STYLE_BRACKET;
    end
  endtask

  task automatic scan_item(output logic has_verdict, output line_verdict_t v);
    glyph_flags_t f;
    logic [15:0]  code;
    f    = is_character ? {1'b1, space_flag, digit_flag, dot_flag, alnum_flag} : '0;
    code = is_character ? char_code : '0;
    case (scan_phase)
      PH_LEAD: begin
        if (!f.sp) begin
          tok_start     = pos;
          lone_symbol   = !f.an;
          opens_bracket = f.chr && code == CH_OPEN_BR;
          held_flags    = f;
          held_code     = code;
          multi_item    = 1'b0;
          scan_phase    = PH_TOKEN;
        end
      end
      PH_TOKEN: begin
        if (f.sp) begin
          tok_end    = pos;
          scan_phase = PH_GAP;
        end else begin
          absorb_held();
          multi_item = 1'b1;
          held_flags = f;
          held_code  = code;
        end
      end
      PH_GAP: begin
        if (!f.sp) begin
          judge_marker();
          found_left = left_coord;
          scan_phase = PH_DONE;
        end
      end
      default: begin
      end
    endcase
    if (pos < INDEX_CAP) pos = pos + 1'b1;

    has_verdict = line_end;
    v = '{KIND_NONE, STYLE_NONE, '0, '0, '0};
    if (line_end) begin
      if (scan_phase == PH_DONE && found_kind != KIND_NONE)
        v = '{found_kind, found_style, found_left, tok_start, tok_end};
      restart_line();
    end
  endtask

  always @(posedge clk) begin : watch
    logic          has_verdict;
    line_verdict_t fresh;
    line_verdict_t want;
    if (rst) begin
      restart_line();
      verdicts_due.delete();
    end else begin
      if (in_valid && in_ready) begin
        scan_item(has_verdict, fresh);
        if (has_verdict) verdicts_due = {verdicts_due, fresh};
      end
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result beat with no line outstanding: kind %0d style %0d left %h",
                     $time, list_kind, number_style, text_left);
        end else begin
          want = verdicts_due.pop_front();
          if (list_kind !== want.kind || number_style !== want.style ||
              text_left !== want.left || marker_first !== want.first ||
              marker_after !== want.after) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: line result (expected/actual): kind %0d/%0d style %0d/%0d ",
                       $time, want.kind, list_kind, want.style, number_style,
                       "left %h/%h first %0d/%0d after %0d/%0d",
                       want.left, text_left, want.first, marker_first,
                       want.after, marker_after);
          end
        end
      end
    end
    lines_pending <= verdicts_due.size();
  end

endmodule

@@ test/list_marker_classifier_tb.sv @@
`timescale 1ns / 100ps
module list_marker_classifier_tb;
  import lmc_pkg::*;

  localparam logic [15:0] CH_SPACE  = 16'h0020;
  localparam logic [15:0] CH_TAB    = 16'h0009;
  localparam logic [15:0] CH_NBSP   = 16'h00A0;
  localparam logic [15:0] CH_IDEO   = 16'h3000;
  localparam logic [15:0] CH_DOT    = 16'h002E;
  localparam logic [15:0] CH_ZERO   = 16'h0030;
  localparam logic [15:0] CH_STAR   = 16'h002A;
  localparam logic [15:0] CH_DASH   = 16'h002D;
  localparam logic [15:0] CH_BULLET = 16'h2022;
  localparam logic [15:0] CH_TOP    = 16'hFFFF;
  localparam int RANDOM_ITEMS = 600;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  typedef struct {
    logic               chr;
    logic [15:0]        code;
    logic               sp;
    logic               dg;
    logic               dt;
    logic               an;
    logic signed [31:0] left;
    logic               last;
  } page_item_t;

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               in_valid     = 1'b0;
  logic               is_character = 1'b0;
  logic [15:0]        char_code    = '0;
  logic               space_flag   = 1'b0;
  logic               digit_flag   = 1'b0;
  logic               dot_flag     = 1'b0;
  logic               alnum_flag   = 1'b0;
  logic signed [31:0] left_coord   = '0;
  logic               line_end     = 1'b0;
  logic               out_ready    = 1'b0;
  logic               in_ready;
  logic               out_valid;
  logic [1:0]         list_kind;
  logic [1:0]         number_style;
  logic signed [31:0] text_left;
  logic [IDX_W-1:0]   marker_first;
  logic [IDX_W-1:0]   marker_after;
  int                 mismatch_count;
  int                 lines_pending;

  page_item_t line_q[$];
  int         burst_left;
  int         items_sent;
  rx_mode_t   rx_mode;
  int         rx_left;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  list_marker_classifier dut (
    .clk, .rst, .in_valid, .in_ready, .is_character, .char_code, .space_flag,
    .digit_flag, .dot_flag, .alnum_flag, .left_coord, .line_end, .out_valid,
    .out_ready, .list_kind, .number_style, .text_left, .marker_first, .marker_after
  );

  list_marker_classifier_checker line_check (
    .clk, .rst, .in_valid, .in_ready, .is_character, .char_code, .space_flag,
    .digit_flag, .dot_flag, .alnum_flag, .left_coord, .line_end, .out_valid,
    .out_ready, .list_kind, .number_style, .text_left, .marker_first, .marker_after,
    .mismatch_count, .lines_pending
  );

  // The receiver moves between stretches of full readiness and stalls of varying density.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_mode   = RX_OPEN;
      rx_left   = 0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(10, 60);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
        default:   out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  function automatic page_item_t glyph(input logic [15:0] c);
    page_item_t it;
    it.chr  = 1'b1;
    it.code = c;
    it.sp   = (c == CH_SPACE);
    it.dg   = (c >= CH_ZERO && c <= CH_ZERO + 9);
    it.dt   = (c == CH_DOT);
    // Digits and ASCII letters in either case
    it.an   = it.dg || (c >= 16'h0041 && c <= 16'h005A) || (c >= 16'h0061 && c <= 16'h007A);
    it.left = $urandom;
    it.last = 1'b0;
    return it;
  endfunction

  function automatic page_item_t blank();
    page_item_t it;
    it = glyph(CH_SPACE);
    case ($urandom_range(0, 3))
      0: it.code = CH_TAB;
      1: it.code = CH_NBSP;
      2: it.code = CH_IDEO;
      default: it.code = CH_SPACE;
    endcase
    it.sp = 1'b1;
    return it;
  endfunction

  // Flags and code of a non-glyph item carry junk that the block must ignore.
  function automatic page_item_t other_item();
    page_item_t it;
    it      = glyph(16'($urandom));
    it.chr  = 1'b0;
    it.sp   = 1'($urandom_range(0, 1));
    it.dg   = 1'($urandom_range(0, 1));
    it.dt   = 1'($urandom_range(0, 1));
    it.an   = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic page_item_t noise_item();
    page_item_t it;
    it     = other_item();
    it.chr = 1'b1;
    return it;
  endfunction

  function automatic page_item_t letter();
    return glyph(16'(($urandom_range(0, 1) ? 16'h0041 : 16'h0061) + $urandom_range(0, 25)));
  endfunction

  function automatic page_item_t digit();
    return glyph(16'(CH_ZERO + $urandom_range(0, 9)));
  endfunction

  function automatic page_item_t numeral_part();
    return ($urandom_range(0, 3) == 0) ? glyph(CH_DOT) : digit();
  endfunction

  function automatic page_item_t roman_part(input logic caps);
    case ($urandom_range(0, 4))
      0: return glyph(caps ? CH_UPPER_I : CH_LOWER_I);
      1: return glyph(caps ? CH_UPPER_V : CH_LOWER_V);
      2: return glyph(caps ? CH_UPPER_X : CH_LOWER_X);
      3: return glyph(caps ? CH_UPPER_I : CH_LOWER_I);
      default: return glyph(CH_DOT);
    endcase
  endfunction

  function automatic page_item_t closing_mark();
    case ($urandom_range(0, 6))
      0, 1, 2: return glyph(CH_DOT);
      3, 4:    return glyph(CH_COLON);
      5:       return glyph(CH_CLOSE_BR);
      default: return noise_item();
    endcase
  endfunction

  function automatic page_item_t text_item();
    case ($urandom_range(0, 7))
      0:       return other_item();
      1:       return noise_item();
      2:       return digit();
      3:       return blank();
      4:       return glyph(CH_DOT);
      default: return letter();
    endcase
  endfunction

  task automatic add_item(input page_item_t it);
    line_q = {line_q, it};
  endtask

  task automatic send_beat(input page_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    is_character <= it.chr;
    char_code    <= it.code;
    space_flag   <= it.sp;
    digit_flag   <= it.dg;
    dot_flag     <= it.dt;
    alnum_flag   <= it.an;
    left_coord   <= it.left;
    line_end     <= it.last;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_line();
    line_q[line_q.size() - 1].last = 1'b1;
    foreach (line_q[i]) send_beat(line_q[i]);
    items_sent += line_q.size();
    line_q.delete();
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (lines_pending != 0);
    burst_left = 0;
  endtask

  task automatic build_random_line();
    int         shape;
    int         base;
    logic       caps;
    logic       tail;
    tail  = 1'b1;
    shape = $urandom_range(0, 9);
    repeat ($urandom_range(0, 3)) add_item(blank());
    base = line_q.size();
    case (shape)
      0, 1: begin
        case ($urandom_range(0, 4))
          0: add_item(glyph(CH_STAR));
          1: add_item(glyph(CH_DASH));
          2: add_item(glyph(CH_BULLET));
          3: add_item(other_item());
          default: add_item(noise_item());
        endcase
      end
      2, 3: begin
        repeat ($urandom_range(1, 4)) add_item(numeral_part());
        add_item(closing_mark());
      end
      4, 5: begin
        caps = 1'($urandom_range(0, 1));
        // Now and then one letter of the other case slips in.
        repeat ($urandom_range(1, 4))
          add_item(roman_part(caps ^ ($urandom_range(0, 7) == 0)));
        add_item(closing_mark());
      end
      6: begin
        add_item(glyph(CH_OPEN_BR));
        repeat ($urandom_range(0, 3))
          add_item(($urandom_range(0, 7) == 0) ? letter() : numeral_part());
        add_item(($urandom_range(0, 5) == 0) ? closing_mark() : glyph(CH_CLOSE_BR));
      end
      7: begin
        repeat ($urandom_range(1, 5))
          add_item($urandom_range(0, 1) ? noise_item() : text_item());
      end
      8: begin
        tail = 1'b0;
        case ($urandom_range(0, 2))
          0: add_item(blank());
          1: repeat ($urandom_range(1, 3)) add_item(numeral_part());
          default: begin
            add_item(digit());
            add_item(glyph(CH_DOT));
            repeat ($urandom_range(1, 2)) add_item(blank());
          end
        endcase
      end
      default: begin
        repeat ($urandom_range(1, 3)) add_item(numeral_part());
        add_item(glyph(CH_DOT));
        line_q[base + $urandom_range(0, line_q.size() - 1 - base)] = noise_item();
      end
    endcase
    if (tail) begin
      repeat ($urandom_range(1, 3)) add_item(blank());
      add_item(($urandom_range(0, 3) == 0) ? other_item() : letter());
      repeat ($urandom_range(0, 4)) add_item(text_item());
    end
  endtask

  initial begin
    page_item_t it;
    logic       drained;
    burst_left = 0;
    items_sent = 0;
    drained    = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Bullet with the most negative text coordinate.
    add_item(glyph(CH_STAR));
    add_item(blank());
    it = letter();
    it.left = 32'sh8000_0000;
    add_item(it);
    send_line();
    // Decimal marker closed by a colon, most positive coordinate.
    add_item(digit());
    add_item(glyph(CH_COLON));
    add_item(blank());
    it = letter();
    it.left = 32'sh7FFF_FFFF;
    add_item(it);
    send_line();
    // Upper-case roman marker.
    add_item(glyph(CH_UPPER_I));
    add_item(glyph(CH_UPPER_X));
    add_item(glyph(CH_DOT));
    add_item(blank());
    add_item(letter());
    send_line();
    // Bracketed decimal, text starting with a non-glyph item.
    add_item(glyph(CH_OPEN_BR));
    add_item(digit());
    add_item(glyph(CH_CLOSE_BR));
    add_item(blank());
    add_item(other_item());
    send_line();
    // A line of white space only.
    add_item(blank());
    send_line();
    // The token runs into the end of the line.
    add_item(glyph(CH_TOP));
    add_item(letter());
    send_line();
    // Marker and gap but no text.
    add_item(digit());
    add_item(glyph(CH_DOT));
    add_item(blank());
    send_line();
    wait_all_results();

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      build_random_line();
      send_line();
      if (!drained && items_sent >= RANDOM_ITEMS / 2) begin
        wait_all_results();
        drained = 1'b1;
      end
    end
    wait_all_results();
    repeat (20) @(posedge clk);

    if (mismatch_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ list_marker_classifier.f @@
hdl/lmc_pkg.sv
hdl/list_marker_classifier.sv
test/list_marker_classifier_checker.sv
test/list_marker_classifier_tb.sv
